// ----- rtl/core/pscl_pkg.sv -----
// ----------------------------------------------------------------------------
// pscl_pkg
// Shared types, token codes and the keyword table of the Pascal-style
// tokenizer.
// ----------------------------------------------------------------------------
package pscl_pkg;

  localparam int LineBitsDef     = 20;
  localparam int ColumnBitsDef   = 16;
  localparam int MaxKeywordLenDef = 12;

  localparam int NumKw      = 17;
  localparam int KwChars    = 16;
  localparam int OutLineW   = 20;
  localparam int OutColW    = 16;
  localparam int LenW       = 16;
  localparam int KindW      = 6;

  localparam logic [KindW-1:0] KIdent  = 6'd17;
  localparam logic [KindW-1:0] KNumber = 6'd18;
  localparam logic [KindW-1:0] KString = 6'd19;
  localparam logic [KindW-1:0] KPlus   = 6'd20;
  localparam logic [KindW-1:0] KMinus  = 6'd21;
  localparam logic [KindW-1:0] KStar   = 6'd22;
  localparam logic [KindW-1:0] KSlash  = 6'd23;
  localparam logic [KindW-1:0] KEq     = 6'd24;
  localparam logic [KindW-1:0] KNe     = 6'd25;
  localparam logic [KindW-1:0] KLt     = 6'd26;
  localparam logic [KindW-1:0] KLe     = 6'd27;
  localparam logic [KindW-1:0] KGt     = 6'd28;
  localparam logic [KindW-1:0] KGe     = 6'd29;
  localparam logic [KindW-1:0] KAssign = 6'd30;
  localparam logic [KindW-1:0] KSemi   = 6'd31;
  localparam logic [KindW-1:0] KDot    = 6'd32;
  localparam logic [KindW-1:0] KComma  = 6'd33;
  localparam logic [KindW-1:0] KColon  = 6'd34;
  localparam logic [KindW-1:0] KLParen = 6'd35;
  localparam logic [KindW-1:0] KRParen = 6'd36;
  localparam logic [KindW-1:0] KLBrack = 6'd37;
  localparam logic [KindW-1:0] KRBrack = 6'd38;
  localparam logic [KindW-1:0] KEnd    = 6'd39;
  localparam logic [KindW-1:0] KError  = 6'd40;

  // keyword text, right-justified (last character in the low byte)
  localparam logic [8*KwChars-1:0] KwText [NumKw] = '{
    128'("programa"), 128'("inicio"), 128'("fim"), 128'("var"),
    128'("inteiro"), 128'("logico"), 128'("se"), 128'("entao"),
    128'("senao"), 128'("enquanto"), 128'("faca"), 128'("ler"),
    128'("escrever"), 128'("verdadeiro"), 128'("falso"),
    128'({"fim_enq", "uanto"}), 128'("fim_se")
  };
  localparam logic [4:0] KwLen [NumKw] = '{
    5'd8, 5'd6, 5'd3, 5'd3, 5'd7, 5'd6, 5'd2, 5'd5, 5'd5, 5'd8, 5'd4,
    5'd3, 5'd8, 5'd10, 5'd5, 5'd12, 5'd6
  };

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [OutLineW-1:0] line;
    logic [OutColW-1:0]  col;
    logic [LenW-1:0]     len;
    logic                last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok1;
    token_t     tok0;
  } step_res_t;

  // character idx of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input int k, input logic [LenW-1:0] idx);
    logic [8*KwChars-1:0] txt;
    logic [4:0]           ln;
    logic [4:0]           pos;
    txt = KwText[k];
    ln  = KwLen[k];
    pos = ln - 5'd1 - idx[4:0];
    if (idx < LenW'(ln)) begin
      return txt[8*pos +: 8];
    end
    return 8'd0;
  endfunction

  function automatic logic [KindW-1:0] single_kind(input logic [7:0] c);
    case (c)
      8'h2B:   return KPlus;
      8'h2D:   return KMinus;
      8'h2A:   return KStar;
      8'h2F:   return KSlash;
      8'h3D:   return KEq;
      8'h3B:   return KSemi;
      8'h2E:   return KDot;
      8'h2C:   return KComma;
      8'h28:   return KLParen;
      8'h29:   return KRParen;
      8'h5B:   return KLBrack;
      8'h5D:   return KRBrack;
      default: return KError;
    endcase
  endfunction

endpackage

// ----- rtl/core/pascal_style_tokenizer.sv -----
// ----------------------------------------------------------------------------
// pascal_style_tokenizer
// Byte-stream lexer for a Pascal-like language; emits one token per transfer.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                        tuser         tlast
// s_axis    in   ch[7:0]                      end_of_text   -
// m_axis    out  kind,start_line,start_column,token_length  last
//
// Each byte is decoded in the cycle it is taken; tokens land in a 4-entry
// queue and leave one per cycle while m_axis is ready. Input is taken while
// the queue holds at most two tokens, so a steady one byte per cycle holds
// unless the output stalls or bytes that raise two tokens outpace the output.
// Reset returns to line 1, column 1, between tokens, with an empty queue.
module pascal_style_tokenizer #(
  parameter int LINE_BITS       = pscl_pkg::LineBitsDef,
  parameter int COLUMN_BITS     = pscl_pkg::ColumnBitsDef,
  parameter int MAX_KEYWORD_LEN = pscl_pkg::MaxKeywordLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tuser_i,   // [0] end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // kind[5:0], start_line[25:6],
                                        // start_column[41:26], token_length[57:42]
  output logic        m_axis_tlast_o
);
  import pscl_pkg::*;

  step_res_t  res;
  token_t     tok;
  logic       in_acc;
  logic [2:0] cnt;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  pscl_scan #(
    .LINE_BITS      (LINE_BITS),
    .COLUMN_BITS    (COLUMN_BITS),
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_acc),
    .ch_i  (s_axis_tdata_i),
    .eot_i (s_axis_tuser_i),
    .res_o (res)
  );

  pscl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_acc),
    .res_i  (res),
    .room2_o(s_axis_tready_o),
    .valid_o(m_axis_tvalid_o),
    .pop_i  (m_axis_tready_i),
    .tok_o  (tok),
    .count_o(cnt)
  );

  assign m_axis_tdata_o = {6'd0, tok.len, tok.col, tok.line, tok.kind};
  assign m_axis_tlast_o = tok.last;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= 3'd4) else $error("token queue overflow");

  a_end_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i || s_axis_tdata_i == 8'd0) |-> res.count != 2'd0)
    else $error("end of text produced no token");

  a_last_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res.count == 2'd2 |-> res.tok1.last && !res.tok0.last)
    else $error("last flag misplaced on token pair");

endmodule

// ----- rtl/core/pscl_scan.sv -----
// ----------------------------------------------------------------------------
// pscl_scan
// Scanner state and one-pass decode of a text byte into up to two tokens.
// ----------------------------------------------------------------------------
module pscl_scan #(
  parameter int LINE_BITS       = pscl_pkg::LineBitsDef,
  parameter int COLUMN_BITS     = pscl_pkg::ColumnBitsDef,
  parameter int MAX_KEYWORD_LEN = pscl_pkg::MaxKeywordLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          ch_i,
  input  logic                eot_i,
  output pscl_pkg::step_res_t res_o
);
  import pscl_pkg::*;

  typedef enum logic [2:0] {
    MIdle, MIdent, MNumber, MString, MComment, MLt, MGt, MColon
  } mode_e;

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [31:0] OutLineMax = 32'((64'd1 << OutLineW) - 64'd1);
  localparam logic [31:0] OutColMax  = 32'((64'd1 << OutColW) - 64'd1);

  mode_e                  mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d, tline_q, tline_d, line_mv;
  logic [COLUMN_BITS-1:0] col_q, col_d, tcol_q, tcol_d, col_mv;
  logic [LenW-1:0]        len_q, len_d, len_inc, abs_idx;
  logic [NumKw-1:0]       cand_q, cand_d, keep, cand_abs;
  logic [KindW-1:0]       ident_kind;
  logic [7:0]             lc;
  logic                   is_al, is_dg, is_sp, is_idc, at_end;
  logic [OutLineW-1:0]    tline_o, line_o;
  logic [OutColW-1:0]     tcol_o, col_o;
  logic                   pend_v;
  logic [KindW-1:0]       pend_kind;
  logic [LenW-1:0]        pend_len;
  token_t                 tok [2];
  logic [1:0]             n;
  logic                   fall;

  always_comb begin
    lc     = (ch_i >= 8'h41 && ch_i <= 8'h5A) ? ch_i + 8'd32 : ch_i;
    is_al  = (lc >= 8'h61 && lc <= 8'h7A);
    is_dg  = (ch_i >= 8'h30 && ch_i <= 8'h39);
    is_sp  = (ch_i == 8'h20) || (ch_i >= 8'h09 && ch_i <= 8'h0D);
    is_idc = is_al || is_dg || ch_i == ChUnder;
    at_end = eot_i || ch_i == 8'd0;
    len_inc = (len_q == '1) ? len_q : len_q + 1'b1;

    // position after this byte
    if (ch_i == ChLf) begin
      line_mv = (line_q == '1) ? line_q : line_q + 1'b1;
      col_mv  = COLUMN_BITS'(1);
    end else begin
      line_mv = line_q;
      col_mv  = (col_q == '1) ? col_q : col_q + 1'b1;
    end

    // saturate positions to the output widths
    tline_o = (32'(tline_q) > OutLineMax) ? OutLineW'(OutLineMax) : OutLineW'(32'(tline_q));
    line_o  = (32'(line_q) > OutLineMax) ? OutLineW'(OutLineMax) : OutLineW'(32'(line_q));
    tcol_o  = (32'(tcol_q) > OutColMax) ? OutColW'(OutColMax) : OutColW'(32'(tcol_q));
    col_o   = (32'(col_q) > OutColMax) ? OutColW'(OutColMax) : OutColW'(32'(col_q));

    // keyword filter for the byte being absorbed
    abs_idx = (mode_q == MIdent) ? len_q : '0;
    for (int k = 0; k < NumKw; k++) begin
      keep[k] = (32'(abs_idx) < 32'(MAX_KEYWORD_LEN)) && (kw_char(k, abs_idx) == lc);
    end
    cand_abs = ((mode_q == MIdent) ? cand_q : '1) & keep;

    ident_kind = KIdent;
    if (32'(len_q) <= 32'(MAX_KEYWORD_LEN)) begin
      for (int k = NumKw - 1; k >= 0; k--) begin
        if (cand_q[k] && kw_char(k, len_q) == 8'd0) ident_kind = KindW'(k);
      end
    end

    pend_v    = 1'b1;
    pend_kind = KIdent;
    pend_len  = 16'd1;
    case (mode_q)
      MIdent:  begin pend_kind = ident_kind; pend_len = len_q; end
      MNumber: begin pend_kind = KNumber; pend_len = len_q; end
      MLt:     pend_kind = KLt;
      MGt:     pend_kind = KGt;
      MColon:  pend_kind = KColon;
      default: pend_v = 1'b0;
    endcase

    tok[0] = '0;
    tok[1] = '0;
    n      = 2'd0;
    fall   = 1'b0;
    mode_d = mode_q;
    line_d = line_q;
    col_d  = col_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    len_d   = len_q;
    cand_d  = cand_q;

    if (at_end) begin
      if (mode_q == MString) begin
        tok[n[0]] = '{KError, tline_o, tcol_o, len_q, 1'b0};
        n = n + 2'd1;
      end else if (pend_v) begin
        tok[n[0]] = '{pend_kind, tline_o, tcol_o, pend_len, 1'b0};
        n = n + 2'd1;
      end
      tok[n[0]] = '{KEnd, line_o, col_o, 16'd0, 1'b0};
      n = n + 2'd1;
      mode_d  = MIdle;
      line_d  = LINE_BITS'(1);
      col_d   = COLUMN_BITS'(1);
      tline_d = LINE_BITS'(1);
      tcol_d  = COLUMN_BITS'(1);
      len_d   = '0;
      cand_d  = '1;
    end else begin
      line_d = line_mv;
      col_d  = col_mv;
      case (mode_q)
        MIdent: begin
          if (is_idc) begin
            cand_d = cand_abs;
            len_d  = len_inc;
          end else begin
            tok[n[0]] = '{pend_kind, tline_o, tcol_o, pend_len, 1'b0};
            n = n + 2'd1;
            fall = 1'b1;
          end
        end
        MNumber: begin
          if (is_dg) begin
            len_d = len_inc;
          end else begin
            tok[n[0]] = '{pend_kind, tline_o, tcol_o, pend_len, 1'b0};
            n = n + 2'd1;
            fall = 1'b1;
          end
        end
        MString: begin
          if (ch_i == ChQuote) begin
            tok[n[0]] = '{KString, tline_o, tcol_o, len_q, 1'b0};
            n = n + 2'd1;
            mode_d = MIdle;
          end else begin
            len_d = len_inc;
          end
        end
        MComment: begin
          if (ch_i == ChRBrace) mode_d = MIdle;
        end
        MLt, MGt, MColon: begin
          if (ch_i == ChEq || (ch_i == ChGt && mode_q == MLt)) begin
            tok[n[0]] = '{(mode_q == MLt) ? ((ch_i == ChEq) ? KLe : KNe) :
                          (mode_q == MGt) ? KGe : KAssign,
                          tline_o, tcol_o, 16'd2, 1'b0};
            n = n + 2'd1;
            mode_d = MIdle;
          end else begin
            tok[n[0]] = '{pend_kind, tline_o, tcol_o, pend_len, 1'b0};
            n = n + 2'd1;
            fall = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase

      if (fall) begin
        mode_d = MIdle;
        if (is_sp) begin
          // skip
        end else if (ch_i == ChLBrace) begin
          mode_d = MComment;
        end else if (is_al || ch_i == ChUnder || is_dg || ch_i == ChQuote ||
                     ch_i == ChLt || ch_i == ChGt || ch_i == ChColon) begin
          tline_d = line_q;
          tcol_d  = col_q;
          len_d   = '0;
          cand_d  = '1;
          if (is_al || ch_i == ChUnder) begin
            mode_d = MIdent;
            cand_d = cand_abs;
            len_d  = 16'd1;
          end else if (is_dg) begin
            mode_d = MNumber;
            len_d  = 16'd1;
          end else if (ch_i == ChQuote) begin
            mode_d = MString;
          end else if (ch_i == ChLt) begin
            mode_d = MLt;
          end else if (ch_i == ChGt) begin
            mode_d = MGt;
          end else begin
            mode_d = MColon;
          end
        end else begin
          tok[n[0]] = '{single_kind(ch_i), line_o, col_o, 16'd1, 1'b0};
          n = n + 2'd1;
        end
      end
    end

    // mark the final token of this byte
    if (n == 2'd2) tok[1].last = 1'b1;
    else if (n == 2'd1) tok[0].last = 1'b1;

    res_o.count = n;
    res_o.tok0  = tok[0];
    res_o.tok1  = tok[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MIdle;
      line_q  <= LINE_BITS'(1);
      col_q   <= COLUMN_BITS'(1);
      tline_q <= LINE_BITS'(1);
      tcol_q  <= COLUMN_BITS'(1);
      len_q   <= '0;
      cand_q  <= '1;
    end else if (step_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      len_q   <= len_d;
      cand_q  <= cand_d;
    end
  end

endmodule

// ----- rtl/core/pscl_fifo.sv -----
// ----------------------------------------------------------------------------
// pscl_fifo
// Four-entry token queue; takes up to two tokens per cycle, gives one when popped.
// ----------------------------------------------------------------------------
module pscl_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pscl_pkg::step_res_t res_i,
  output logic                room2_o,
  output logic                valid_o,
  input  logic                pop_i,
  output pscl_pkg::token_t    tok_o,
  output logic [2:0]          count_o
);
  import pscl_pkg::*;

  token_t     mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic [1:0] n_push;
  logic       do_pop;

  assign n_push  = push_i ? res_i.count : 2'd0;
  assign do_pop  = pop_i && cnt_q != 3'd0;
  assign valid_o = cnt_q != 3'd0;
  assign room2_o = cnt_q <= 3'd2;
  assign tok_o   = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= res_i.tok0;
    if (n_push == 2'd2) mem_q[wr_q + 2'd1] <= res_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + {1'b0, do_pop};
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b0, do_pop};
    end
  end

endmodule
